// ===== rtl/ngm_pkg.sv =====
// ngm_pkg: shared types, codes and constants of the nearest glyph match block
// no dependencies
package ngm_pkg;

    // default sizes
    localparam int NUM_GLYPHS_DEF = 256;
    localparam int BLOCK_SIDE_DEF = 8;

    // output distance saturates at this value
    localparam logic [21:0] DIST_MAX = 22'h3F_FFFF;

    // register map, index = byte address / 4
    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_SQUARED   = 2'd0;
    localparam logic [1:0] REG_INVERSION = 2'd1;
    localparam logic [1:0] REG_FLIP      = 2'd2;

    // input operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ALIVE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] glyph_index;
        logic [5:0] pixel_index;
        logic [7:0] pixel_value;
        logic       alive_flag;
        logic       last_pixel;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  best_glyph;
        logic [7:0]  alive_rank;
        logic        inverted;
        logic        mirror_x;
        logic        mirror_y;
        logic [21:0] distance;
        logic        no_glyph;
    } t_out_word;

    // search sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_WAIT,
        ST_CMP,
        ST_DONE
    } t_state;

    // control from the sequencer to the distance accumulators
    typedef struct packed {
        logic clr;
        logic en;
        logic sq;
    } t_dist_ctl;

endpackage

// ===== rtl/ngm_ram.sv =====
// ngm_ram: generic single-port synchronous ram with registered read
// no dependencies
module ngm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ngm_dist.sv =====
// ngm_dist: plain and inverted distance accumulators, one pixel pair per cycle while enabled
// depends on ngm_pkg
module ngm_dist #(
    parameter int ACC_W = 22
) (
    input  logic              i_clk,
    input  ngm_pkg::t_dist_ctl i_ctl,
    input  logic [7:0]        i_query,
    input  logic [7:0]        i_glyph,
    output logic [ACC_W-1:0]  o_acc_plain,
    output logic [ACC_W-1:0]  o_acc_inv
);
    import ngm_pkg::*;

    logic [7:0]       ad_plain;
    logic [7:0]       ad_inv;
    logic [7:0]       glyph_inv;
    logic [15:0]      term_plain;
    logic [15:0]      term_inv;
    logic [ACC_W-1:0] r_acc_plain;
    logic [ACC_W-1:0] r_acc_inv;

    // absolute differences against the glyph and its inverse, squared when sq is set
    always_comb begin
        glyph_inv = 8'd255 - i_glyph;
        ad_plain  = (i_query >= i_glyph) ? i_query - i_glyph : i_glyph - i_query;
        ad_inv    = (i_query >= glyph_inv) ? i_query - glyph_inv : glyph_inv - i_query;
        term_plain = i_ctl.sq ? 16'(ad_plain) * 16'(ad_plain) : 16'(ad_plain);
        term_inv   = i_ctl.sq ? 16'(ad_inv) * 16'(ad_inv) : 16'(ad_inv);
    end

    // clear or accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_plain <= '0;
            r_acc_inv   <= '0;
        end else if (i_ctl.en) begin
            r_acc_plain <= r_acc_plain + ACC_W'(term_plain);
            r_acc_inv   <= r_acc_inv + ACC_W'(term_inv);
        end
    end

    assign o_acc_plain = r_acc_plain;
    assign o_acc_inv   = r_acc_inv;
endmodule

// ===== rtl/nearest_glyph_match_top.sv =====
// nearest_glyph_match_top: codebook search for the glyph nearest to a query block
// depends on ngm_pkg, ngm_ram, ngm_dist
// search: a last query word starts a scan over every glyph index; for each alive
// glyph it runs M mirror passes of P pixels each (P pixels per block, M: 1, or 4
// with flipping), one codebook ram read per cycle, each pass ended by a wait and a
// compare state; then the result is registered. Input words stall while searching.
// reset clears alive flags, config and control only; ram contents stay undefined.
module nearest_glyph_match_top #(
    parameter int NUM_GLYPHS = ngm_pkg::NUM_GLYPHS_DEF,
    parameter int BLOCK_SIDE = ngm_pkg::BLOCK_SIDE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  ngm_pkg::t_in_word         i_word,
    output logic                      o_valid,
    input  logic                      i_stall,
    output ngm_pkg::t_out_word        o_word,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ngm_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ngm_pkg::*;

    localparam int P     = BLOCK_SIDE * BLOCK_SIDE;
    localparam int QAW   = $clog2(P);
    localparam int CBAW  = $clog2(NUM_GLYPHS * P);
    localparam int SW    = $clog2(BLOCK_SIDE);
    localparam int GW    = $clog2(NUM_GLYPHS);
    localparam int GCW   = $clog2(NUM_GLYPHS + 1);
    localparam int ACC_W = $clog2(P * 65025 + 1);

    // configuration
    logic r_squared;
    logic r_inv_en;
    logic r_flip_en;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squared <= 1'b0;
            r_inv_en  <= 1'b1;
            r_flip_en <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SQUARED:   r_squared <= pwdata[0];
                REG_INVERSION: r_inv_en  <= pwdata[0];
                REG_FLIP:      r_flip_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SQUARED:   prdata = {31'd0, r_squared};
            REG_INVERSION: prdata = {31'd0, r_inv_en};
            REG_FLIP:      prdata = {31'd0, r_flip_en};
            default:       prdata = 32'd0;
        endcase
    end

    // sequencer state
    t_state            r_state, n_state;
    logic [GCW-1:0]    r_g;
    logic [GCW-1:0]    r_rank;
    logic [CBAW-1:0]   r_base;
    logic [1:0]        r_f;
    logic [SW-1:0]     r_x;
    logic [SW-1:0]     r_sx;
    logic [QAW-1:0]    r_qrow;
    logic [QAW-1:0]    r_srow;
    logic              r_rd_valid;
    logic [NUM_GLYPHS-1:0] r_alive;

    // best candidate so far
    logic              r_found;
    logic [ACC_W-1:0]  r_best_d;
    logic [GCW-1:0]    r_best_g;
    logic [GCW-1:0]    r_best_rank;
    logic              r_best_inv;
    logic              r_best_mx;
    logic              r_best_my;

    logic              r_out_valid;
    t_out_word         r_out_word;

    // input word decode
    logic              acc_in;
    logic              gi_ok;
    logic              pi_ok;
    logic              start;
    logic [23:0]       cb_waddr_w;
    logic [8:0]        q_waddr_w;

    assign o_stall = (r_state != ST_IDLE);
    assign acc_in  = i_valid & ~o_stall;
    assign gi_ok   = 16'(i_word.glyph_index) < 16'(NUM_GLYPHS);
    assign pi_ok   = 16'(i_word.pixel_index) < 16'(P);
    assign start   = acc_in && (i_word.op == OP_QUERY) && i_word.last_pixel;
    assign cb_waddr_w = 24'(i_word.glyph_index) * 24'(P) + 24'(i_word.pixel_index);
    assign q_waddr_w  = 9'(i_word.pixel_index);

    // glyph currently scanned
    logic g_end;
    logic g_alive;
    logic last_pix;
    logic last_mirror;
    assign g_end       = (r_g == GCW'(NUM_GLYPHS));
    assign g_alive     = r_alive[r_g[GW-1:0]];
    assign last_pix    = (r_x == SW'(BLOCK_SIDE - 1)) &&
                         (r_qrow == QAW'((BLOCK_SIDE - 1) * BLOCK_SIDE));
    assign last_mirror = !r_flip_en || (r_f == 2'd3);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_SCAN;
            ST_SCAN: begin
                if (g_end) n_state = ST_DONE;
                else if (g_alive) n_state = ST_RUN;
            end
            ST_RUN:  if (last_pix) n_state = ST_WAIT;
            ST_WAIT: n_state = ST_CMP;
            ST_CMP:  n_state = last_mirror ? ST_SCAN : ST_RUN;
            ST_DONE: if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    logic [1:0]       pass_f;
    logic             pass_start;
    logic             glyph_next;
    logic             cmp_plain;
    logic             cmp_inv;
    logic [ACC_W-1:0] mid_d;
    logic [ACC_W-1:0] acc_plain;
    logic [ACC_W-1:0] acc_inv;
    t_dist_ctl        dist_ctl;

    always_comb begin
        pass_start = 1'b0;
        glyph_next = 1'b0;
        pass_f     = 2'd0;
        cmp_plain  = 1'b0;
        cmp_inv    = 1'b0;
        mid_d      = r_best_d;
        unique case (r_state)
            ST_SCAN: begin
                pass_start = !g_end && g_alive;
                glyph_next = !g_end && !g_alive;
            end
            ST_CMP: begin
                // plain before inverted, strict improvement only
                cmp_plain = !r_found || (acc_plain < r_best_d);
                mid_d     = cmp_plain ? acc_plain : r_best_d;
                cmp_inv   = r_inv_en && (acc_inv < mid_d);
                pass_start = !last_mirror;
                pass_f     = r_f + 2'd1;
                glyph_next = last_mirror;
            end
            default: ;
        endcase
        dist_ctl.clr = pass_start;
        dist_ctl.en  = r_rd_valid;
        dist_ctl.sq  = r_squared;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_alive     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == ST_RUN);
            if (acc_in && (i_word.op == OP_ALIVE) && gi_ok) begin
                r_alive[i_word.glyph_index[GW-1:0]] <= i_word.alive_flag;
            end
            if (start) begin
                r_found <= 1'b0;
            end else if (cmp_plain || cmp_inv) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_DONE && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // search counters and best candidate
    logic [31:0] best_d32;
    assign best_d32 = 32'(r_best_d);

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_g    <= '0;
            r_rank <= '0;
            r_base <= '0;
        end else if (glyph_next) begin
            r_g    <= r_g + GCW'(1);
            r_base <= r_base + CBAW'(P);
            if (r_state == ST_CMP) r_rank <= r_rank + GCW'(1);
        end
        // walk pixels, source mirrored per pass
        if (pass_start) begin
            r_f    <= pass_f;
            r_x    <= '0;
            r_qrow <= '0;
            r_sx   <= pass_f[1] ? SW'(BLOCK_SIDE - 1) : '0;
            r_srow <= pass_f[0] ? QAW'((BLOCK_SIDE - 1) * BLOCK_SIDE) : '0;
        end else if (r_state == ST_RUN) begin
            if (r_x == SW'(BLOCK_SIDE - 1)) begin
                r_x    <= '0;
                r_sx   <= r_f[1] ? SW'(BLOCK_SIDE - 1) : '0;
                r_qrow <= r_qrow + QAW'(BLOCK_SIDE);
                r_srow <= r_f[0] ? r_srow - QAW'(BLOCK_SIDE) : r_srow + QAW'(BLOCK_SIDE);
            end else begin
                r_x  <= r_x + SW'(1);
                r_sx <= r_f[1] ? r_sx - SW'(1) : r_sx + SW'(1);
            end
        end
        // keep best
        if (cmp_inv) begin
            r_best_d    <= acc_inv;
            r_best_inv  <= 1'b1;
        end else if (cmp_plain) begin
            r_best_d    <= acc_plain;
            r_best_inv  <= 1'b0;
        end
        if (cmp_plain || cmp_inv) begin
            r_best_g    <= r_g;
            r_best_rank <= r_rank;
            r_best_mx   <= r_f[1];
            r_best_my   <= r_f[0];
        end
        // result word
        if (r_state == ST_DONE && (!r_out_valid || !i_stall)) begin
            if (r_found) begin
                r_out_word.best_glyph <= 8'(r_best_g);
                r_out_word.alive_rank <= 8'(r_best_rank);
                r_out_word.inverted   <= r_best_inv;
                r_out_word.mirror_x   <= r_best_mx;
                r_out_word.mirror_y   <= r_best_my;
                r_out_word.distance   <= (best_d32 > 32'(DIST_MAX)) ? DIST_MAX
                                                                     : best_d32[21:0];
                r_out_word.no_glyph   <= 1'b0;
            end else begin
                r_out_word          <= '0;
                r_out_word.no_glyph <= 1'b1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    // codebook and query memories
    logic            cb_we;
    logic            q_we;
    logic [CBAW-1:0] cb_addr;
    logic [QAW-1:0]  q_addr;
    logic [7:0]      cb_rdata;
    logic [7:0]      q_rdata;

    assign cb_we   = acc_in && (i_word.op == OP_LOAD) && gi_ok && pi_ok;
    assign q_we    = acc_in && (i_word.op == OP_QUERY) && pi_ok;
    assign cb_addr = cb_we ? cb_waddr_w[CBAW-1:0]
                           : r_base + CBAW'(r_srow) + CBAW'(r_sx);
    assign q_addr  = q_we ? q_waddr_w[QAW-1:0] : r_qrow + QAW'(r_x);

    ngm_ram #(.WIDTH(8), .DEPTH(NUM_GLYPHS * P)) u_codebook (
        .i_clk   (i_clk),
        .i_we    (cb_we),
        .i_addr  (cb_addr),
        .i_wdata (i_word.pixel_value),
        .o_rdata (cb_rdata)
    );

    ngm_ram #(.WIDTH(8), .DEPTH(P)) u_query (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_addr  (q_addr),
        .i_wdata (i_word.pixel_value),
        .o_rdata (q_rdata)
    );

    ngm_dist #(.ACC_W(ACC_W)) u_dist (
        .i_clk       (i_clk),
        .i_ctl       (dist_ctl),
        .i_query     (q_rdata),
        .i_glyph     (cb_rdata),
        .o_acc_plain (acc_plain),
        .o_acc_inv   (acc_inv)
    );

    // checks
    a_run_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (!g_end && g_alive))
        else $error("pixel pass on a glyph that is not alive");

    a_wait_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |=> (r_state == ST_CMP))
        else $error("compare does not follow last read");

    a_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best_rank <= r_best_g))
        else $error("rank exceeds glyph index");
endmodule
